// ===== sv/frsc_pkg.sv =====
// Shared types and constants for the frame receiver with sum check.
package frsc_pkg;

    localparam int BLOCK_BYTES = 256;
    localparam int WORD_BYTES  = 8;
    localparam int LANE_W      = $clog2(WORD_BYTES);
    localparam int LEN_W       = $clog2(BLOCK_BYTES + 1);
    localparam int RAM_DEPTH   = (BLOCK_BYTES + WORD_BYTES - 1) / WORD_BYTES;
    localparam int RAM_AW      = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int WCNT_W      = $clog2(RAM_DEPTH + 1);

    localparam int TIMER_W     = 16;
    localparam int ADDR_W      = 32;
    localparam int WDATA_W     = 64;
    localparam int BE_W        = 8;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = ADDR_W + WDATA_W + BE_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [7:0]         START_BYTE    = 8'hAA;
    localparam logic [ADDR_W-1:0]  RESET_BASE    = 32'h0800_C800;
    localparam logic [TIMER_W-1:0] RESET_LEN_TO  = 16'd1000;
    localparam logic [TIMER_W-1:0] RESET_DATA_TO = 16'd1000;
    localparam logic [TIMER_W-1:0] RESET_CK_TO   = 16'd500;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_NACK  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_FINAL = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE    = 2'd0,
        CFG_LEN_TO  = 2'd1,
        CFG_DATA_TO = 2'd2,
        CFG_CK_TO   = 2'd3
    } cfg_idx_t;

    typedef enum logic [9:0] {
        ST_HUNT    = 10'b00_0000_0001,
        ST_LEN_HI  = 10'b00_0000_0010,
        ST_LEN_LO  = 10'b00_0000_0100,
        ST_DATA    = 10'b00_0000_1000,
        ST_CK_HI   = 10'b00_0001_0000,
        ST_CK_LO   = 10'b00_0010_0000,
        ST_DONE    = 10'b00_0100_0000,
        ST_EMIT_RD = 10'b00_1000_0000,
        ST_EMIT_WR = 10'b01_0000_0000,
        ST_EMIT_AK = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic clr_timer;
        logic tick_timer;
        logic ld_len_hi;
        logic ld_len;
        logic data_byte;
        logic ld_ck_hi;
        logic clr_word;
        logic rd_word;
        logic out_nack;
        logic out_final;
        logic out_write;
        logic out_ack;
    } cmd_t;

    typedef struct packed {
        logic sof_hit;
        logic len_too_big;
        logic len_zero;
        logic data_last;
        logic sum_match;
        logic to_len;
        logic to_data;
        logic to_ck;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

// ===== sv/frsc_ram.sv =====
// Generic single-port-write, registered-read RAM.
module frsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== sv/frsc_ctrl.sv =====
// Frame receiver controller: phase state machine and input handshake.
module frsc_ctrl import frsc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic tick,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   accept_ok;
    logic   acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        case (state_reg)
            ST_HUNT, ST_LEN_HI, ST_LEN_LO, ST_DATA,
            ST_CK_HI, ST_CK_LO, ST_DONE: accept_ok = 1'b1;
            default:                     accept_ok = 1'b0;
        endcase
    end

    assign s_tready = accept_ok && sts.out_free;
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_HUNT: begin
                if (acc && !tick && sts.sof_hit) begin
                    cmd.clr_timer = 1'b1;
                    state_next    = ST_LEN_HI;
                end
            end
            ST_DONE: begin
            end
            ST_LEN_HI, ST_LEN_LO, ST_DATA, ST_CK_HI, ST_CK_LO: begin
                if (acc && tick) begin
                    cmd.tick_timer = 1'b1;
                    if (((state_reg == ST_LEN_HI || state_reg == ST_LEN_LO) && sts.to_len)
                        || (state_reg == ST_DATA && sts.to_data)
                        || ((state_reg == ST_CK_HI || state_reg == ST_CK_LO)
                            && sts.to_ck)) begin
                        cmd.clr_timer = 1'b1;
                        cmd.out_nack  = 1'b1;
                        state_next    = ST_HUNT;
                    end
                end else if (acc) begin
                    case (state_reg)
                        ST_LEN_HI: begin
                            cmd.ld_len_hi = 1'b1;
                            state_next    = ST_LEN_LO;
                        end
                        ST_LEN_LO: begin
                            cmd.clr_timer = 1'b1;
                            if (sts.len_too_big) begin
                                cmd.out_nack = 1'b1;
                                state_next   = ST_HUNT;
                            end else if (sts.len_zero) begin
                                cmd.out_final = 1'b1;
                                state_next    = ST_DONE;
                            end else begin
                                cmd.ld_len = 1'b1;
                                state_next = ST_DATA;
                            end
                        end
                        ST_DATA: begin
                            cmd.data_byte = 1'b1;
                            if (sts.data_last) begin
                                cmd.clr_timer = 1'b1;
                                state_next    = ST_CK_HI;
                            end
                        end
                        ST_CK_HI: begin
                            cmd.ld_ck_hi = 1'b1;
                            state_next   = ST_CK_LO;
                        end
                        default: begin
                            cmd.clr_timer = 1'b1;
                            if (sts.sum_match) begin
                                cmd.clr_word = 1'b1;
                                state_next   = ST_EMIT_RD;
                            end else begin
                                cmd.out_nack = 1'b1;
                                state_next   = ST_HUNT;
                            end
                        end
                    endcase
                end
            end
            ST_EMIT_RD: begin
                cmd.rd_word = 1'b1;
                state_next  = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (sts.out_free) begin
                    cmd.out_write = 1'b1;
                    state_next    = sts.emit_last ? ST_EMIT_AK : ST_EMIT_RD;
                end
            end
            ST_EMIT_AK: begin
                if (sts.out_free) begin
                    cmd.out_ack = 1'b1;
                    state_next  = ST_HUNT;
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

endmodule

// ===== sv/frsc_dp.sv =====
// Frame receiver datapath: registers, timer, sum, word packing and result register.
module frsc_dp import frsc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            rx_byte,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    logic [TIMER_W-1:0] len_to_reg;
    logic [TIMER_W-1:0] data_to_reg;
    logic [TIMER_W-1:0] ck_to_reg;

    logic [TIMER_W-1:0] timer_reg;
    logic [7:0]         len_hi_reg;
    logic [LEN_W-1:0]   blk_len_reg;
    logic [LEN_W-1:0]   count_reg;
    logic [15:0]        sum_reg;
    logic [7:0]         ck_hi_reg;
    logic [ADDR_W-1:0]  next_addr_reg;
    logic [WDATA_W-1:0] word_reg;
    logic [WCNT_W-1:0]  wcnt_reg;

    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [WDATA_W-1:0] out_data_reg;
    logic [BE_W-1:0]    out_be_reg;
    logic               out_last_reg;

    logic [TIMER_W-1:0] timer_next;
    logic [15:0]        len_word;
    logic [LANE_W-1:0]  lane;
    logic [WDATA_W-1:0] word_next;
    logic               ram_wr;
    logic [RAM_AW-1:0]  ram_wr_addr;
    logic [WDATA_W-1:0] ram_rd_data;
    logic [WCNT_W-1:0]  nwords;
    logic [LEN_W-1:0]   word_off;
    logic [LEN_W-1:0]   remain;
    logic [BE_W-1:0]    be_val;
    logic               load_out;

    assign timer_next  = (timer_reg == '1) ? timer_reg : timer_reg + 1'b1;
    assign len_word    = {len_hi_reg, rx_byte};
    assign lane        = count_reg[LANE_W-1:0];
    assign word_next   = (lane == '0) ? WDATA_W'(rx_byte)
                                      : word_reg | (WDATA_W'(rx_byte) << {lane, 3'b000});
    assign ram_wr      = cmd.data_byte && ((lane == LANE_W'(WORD_BYTES - 1)) || sts.data_last);
    assign ram_wr_addr = RAM_AW'(count_reg >> LANE_W);
    assign nwords      = WCNT_W'(((LEN_W + 1)'(blk_len_reg) + (LEN_W + 1)'(WORD_BYTES - 1))
                                 >> LANE_W);
    assign word_off    = LEN_W'({wcnt_reg, {LANE_W{1'b0}}});
    assign remain      = blk_len_reg - word_off;
    assign be_val      = (remain >= LEN_W'(WORD_BYTES)) ? '1
                       : BE_W'((16'd1 << remain[LANE_W:0]) - 16'd1);
    assign load_out    = cmd.out_nack || cmd.out_final || cmd.out_write || cmd.out_ack;

    always_comb begin
        sts.sof_hit     = (rx_byte == START_BYTE);
        sts.len_too_big = (len_word > 16'(BLOCK_BYTES));
        sts.len_zero    = (len_word == '0);
        sts.data_last   = (count_reg + 1'b1 == blk_len_reg);
        sts.sum_match   = ({ck_hi_reg, rx_byte} == sum_reg);
        sts.to_len      = (timer_next >= len_to_reg);
        sts.to_data     = (timer_next >= data_to_reg);
        sts.to_ck       = (timer_next >= ck_to_reg);
        sts.emit_last   = (wcnt_reg + 1'b1 == nwords);
        sts.out_free    = !out_valid_reg || m_tready;
    end

    frsc_ram #(
        .WIDTH (WDATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (ram_wr),
        .wr_addr (ram_wr_addr),
        .wr_data (word_next),
        .rd_en   (cmd.rd_word),
        .rd_addr (RAM_AW'(wcnt_reg)),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_to_reg    <= RESET_LEN_TO;
            data_to_reg   <= RESET_DATA_TO;
            ck_to_reg     <= RESET_CK_TO;
            next_addr_reg <= RESET_BASE;
            timer_reg     <= '0;
            len_hi_reg    <= '0;
            blk_len_reg   <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            ck_hi_reg     <= '0;
            wcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_BASE:    next_addr_reg <= cfg_data;
                    CFG_LEN_TO:  len_to_reg    <= TIMER_W'(cfg_data);
                    CFG_DATA_TO: data_to_reg   <= TIMER_W'(cfg_data);
                    CFG_CK_TO:   ck_to_reg     <= TIMER_W'(cfg_data);
                    default: begin
                    end
                endcase
            end
            if (cmd.clr_timer) begin
                timer_reg <= '0;
            end else if (cmd.tick_timer) begin
                timer_reg <= timer_next;
            end
            if (cmd.ld_len_hi) begin
                len_hi_reg <= rx_byte;
            end
            if (cmd.ld_len) begin
                blk_len_reg <= LEN_W'(len_word);
                count_reg   <= '0;
                sum_reg     <= '0;
            end
            if (cmd.data_byte) begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + 16'(rx_byte);
            end
            if (cmd.ld_ck_hi) begin
                ck_hi_reg <= rx_byte;
            end
            if (cmd.clr_word) begin
                wcnt_reg <= '0;
            end else if (cmd.out_write) begin
                wcnt_reg <= wcnt_reg + 1'b1;
            end
            if (cmd.out_ack) begin
                next_addr_reg <= next_addr_reg + ADDR_W'(blk_len_reg);
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.data_byte) begin
            word_reg <= word_next;
        end
        if (load_out) begin
            out_addr_reg <= '0;
            out_data_reg <= '0;
            out_be_reg   <= '0;
            out_last_reg <= 1'b1;
            if (cmd.out_write) begin
                out_kind_reg <= KIND_WRITE;
                out_addr_reg <= next_addr_reg + ADDR_W'(word_off);
                out_data_reg <= ram_rd_data;
                out_be_reg   <= be_val;
                out_last_reg <= 1'b0;
            end else if (cmd.out_ack) begin
                out_kind_reg <= KIND_ACK;
            end else if (cmd.out_final) begin
                out_kind_reg <= KIND_FINAL;
            end else begin
                out_kind_reg <= KIND_NACK;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_be_reg, out_data_reg, out_addr_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== sv/frame_receiver_with_sum_check_top.sv =====
// Output: a single result is registered and shown in the cycle after the input transfer that
// produces it. After a matching checksum the buffer is read one 64-bit word at a time, each
// word by a RAM read and then a result load, so a block of L bytes gives ceil(L/8) write words
// and then an ACK; a stalled output holds the write-out.
// Throughput: one input transfer per cycle outside the write-out while the output is not stalled, none during it.
// Reset: synchronous active-low aresetn; the data buffer is not cleared.
module frame_receiver_with_sum_check_top import frsc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]            s_tuser,   // [0] tick
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] write_address, [95:32] write_data,
                                             // [103:96] byte_enable
    output logic [1:0]            m_tuser,   // [1:0] kind
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    frsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .tick     (s_tuser[0]),
        .sts      (sts),
        .cmd      (cmd)
    );

    frsc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rx_byte   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== sv/frsc_chk.sv =====
// Port-level checks for the frame receiver, bound to the top level.
module frsc_chk import frsc_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]            m_tuser,
    input logic                  m_tlast
);

    a_no_take_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while a stalled result blocks the output");

    a_status_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_WRITE |-> m_tdata == '0 && m_tlast)
        else $error("status result carries payload or is not last");

    a_write_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_WRITE |-> !m_tlast && m_tdata[OUT_DATA_W-1 -: BE_W] != '0)
        else $error("write word is last or has no enabled byte");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind frame_receiver_with_sum_check_top frsc_chk u_frsc_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
